[rtl/core/mmh_pkg.sv]
// ----------------------------------------------------------------------------
// mmh_pkg: shared types and constants of the min-max heap engine
// Holds the item structs, command and status codes, and heap sizes.
// ----------------------------------------------------------------------------
package mmh_pkg;
	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int COUNT_W     = $clog2(CAPACITY + 1);
	// wide enough for the last grandchild slot 4*i+6
	localparam int CAND_W      = ADDR_W + 3;

	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DEL_MIN = 2'd1;
	localparam logic [1:0] CMD_DEL_MAX = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]                    cmd;
		logic signed [VALUE_WIDTH-1:0] key_value;
	} req_t;

	typedef struct packed {
		logic [1:0]                    status;
		logic signed [VALUE_WIDTH-1:0] min_value;
		logic signed [VALUE_WIDTH-1:0] max_value;
		logic [COUNT_W-1:0]            entry_count;
	} rsp_t;

	// level parity of slot i: even levels hold minima
	function automatic logic on_min_level(input logic [ADDR_W-1:0] i);
		logic [ADDR_W:0] v;
		logic            par;
		v   = {1'b0, i} + 1'b1;
		par = 1'b0;
		// the highest set bit of i+1 gives the level
		for (int b = 1; b <= ADDR_W; b++) begin
			if (v[b]) par = b[0];
		end
		return ~par;
	endfunction
endpackage

[rtl/core/mmh_ram.sv]
// ----------------------------------------------------------------------------
// mmh_ram: generic single-port RAM with registered read
// One write or one read per cycle.
// ----------------------------------------------------------------------------
module mmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

[rtl/core/min_max_heap_engine.sv]
// ----------------------------------------------------------------------------
// min_max_heap_engine: double-ended priority queue as a min-max heap
// Insert, delete-min, delete-max on up to CAPACITY signed values.
// ----------------------------------------------------------------------------
// channel | dir | signals    | accepted when
// request | in  | start, req | start && !busy
// result  | out | done, rsp  | done high (one cycle)
//
// All heap traffic shares one RAM port and one comparator.
// Reset clears the count and control registers, not the RAM; slots at or above the count are never used.
// busy stays high from acceptance until the cycle done is shown.
// The receiver cannot stall: done is a one-cycle strobe.
module min_max_heap_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mmh_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output mmh_pkg::rsp_t rsp
);
	import mmh_pkg::*;

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [ADDR_W-1:0]      adr_t;
	typedef logic [CAND_W-1:0]      cand_t;

	typedef enum logic [4:0] {
		S_IDLE, S_INS_W, S_UP_RP, S_UP_WP, S_UP_SW1, S_UP_SW2,
		S_CL_START, S_CL_RG, S_CL_WG, S_CL_SW1, S_CL_SW2,
		S_DX_R1, S_DX_R2, S_DX_CMP,
		S_RM_RL, S_RM_WL, S_RM_WR,
		S_DN_RD, S_DN_WD, S_DN_CMP, S_DN_SWI, S_DN_SWM, S_DN_RP, S_DN_WP,
		S_DN_PSW, S_DN_PSW2,
		S_OUT_R0, S_OUT_R1, S_OUT_R2, S_OUT_R3, S_OUT
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [1:0]         status_q;
	adr_t               i_q, j_q, m_q;
	val_t               vi_q, vj_q, vm_q;
	logic               want_max_q;
	logic [2:0]         step_q;
	val_t               mn_q, mx_q;

	logic ram_we;
	adr_t ram_addr;
	val_t ram_wdata, ram_rdata;

	mmh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// shared comparator, biased values so unsigned order is signed order
	val_t cmp_a, cmp_b;
	logic cmp_gt, cmp_lt;
	assign cmp_gt = cmp_a > cmp_b;
	assign cmp_lt = cmp_a < cmp_b;

	logic better_dn;
	assign better_dn = want_max_q ? cmp_gt : cmp_lt;

	function automatic adr_t par(input adr_t a);
		return adr_t'((a - 1'b1) >> 1);
	endfunction

	// candidate slot for the child/grandchild scan of node i_q
	cand_t cand;
	always_comb begin
		if (step_q < 3'd2)
			cand = CAND_W'({i_q, 1'b1}) + CAND_W'(step_q);
		else
			cand = CAND_W'({i_q, 2'b11}) + CAND_W'(step_q - 3'd2);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = i_q;
		ram_wdata = vi_q;
		cmp_a     = vi_q;
		cmp_b     = vj_q;
		case (state_q)
			S_INS_W:   ram_we = 1'b1;
			S_UP_RP:   ram_addr = j_q;
			S_UP_WP:   cmp_b = ram_rdata;
			S_UP_SW1, S_CL_SW1: begin
				ram_we = 1'b1; ram_addr = i_q; ram_wdata = vj_q;
			end
			S_UP_SW2, S_CL_SW2: begin
				ram_we = 1'b1; ram_addr = j_q; ram_wdata = vi_q;
			end
			S_CL_RG:   ram_addr = j_q;
			S_CL_WG:   cmp_b = ram_rdata;
			S_DX_R1:   ram_addr = adr_t'(1);
			S_DX_R2:   ram_addr = adr_t'(2);
			S_DX_CMP:  begin cmp_a = ram_rdata; cmp_b = vj_q; end
			S_RM_RL:   ram_addr = cnt_q[ADDR_W-1:0];
			S_RM_WR:   ram_we = 1'b1;
			S_DN_RD:   ram_addr = cand[ADDR_W-1:0];
			S_DN_WD:   begin cmp_a = ram_rdata; cmp_b = vm_q; end
			S_DN_CMP:  begin cmp_a = vm_q; cmp_b = vi_q; end
			S_DN_SWI:  begin ram_we = 1'b1; ram_addr = i_q; ram_wdata = vm_q; end
			S_DN_SWM:  begin ram_we = 1'b1; ram_addr = m_q; ram_wdata = vi_q; end
			S_DN_RP:   ram_addr = par(m_q);
			S_DN_WP:   begin cmp_a = ram_rdata; cmp_b = vi_q; end
			S_DN_PSW:  begin ram_we = 1'b1; ram_addr = m_q; ram_wdata = vj_q; end
			S_DN_PSW2: begin ram_we = 1'b1; ram_addr = par(m_q); ram_wdata = vi_q; end
			S_OUT_R0:  ram_addr = adr_t'(0);
			S_OUT_R1:  ram_addr = adr_t'(1);
			S_OUT_R2:  ram_addr = adr_t'(2);
			S_OUT_R3:  begin cmp_a = ram_rdata; cmp_b = mx_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			busy       <= 1'b0;
			done       <= 1'b0;
			status_q   <= ST_OK;
			i_q        <= '0;
			j_q        <= '0;
			m_q        <= '0;
			vi_q       <= '0;
			vj_q       <= '0;
			vm_q       <= '0;
			want_max_q <= 1'b0;
			step_q     <= '0;
			mn_q       <= '0;
			mx_q       <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy     <= 1'b1;
						status_q <= ST_OK;
						vi_q     <= {~req.key_value[VALUE_WIDTH-1],
							req.key_value[VALUE_WIDTH-2:0]};
						state_q  <= S_OUT_R0;
						case (req.cmd)
							CMD_INSERT: begin
								if (cnt_q >= COUNT_W'(CAPACITY)) status_q <= ST_FULL;
								else begin
									i_q     <= adr_t'(cnt_q);
									cnt_q   <= cnt_q + 1'b1;
									state_q <= S_INS_W;
								end
							end
							CMD_DEL_MIN: begin
								if (cnt_q == '0) status_q <= ST_EMPTY;
								else begin
									cnt_q      <= cnt_q - 1'b1;
									i_q        <= '0;
									want_max_q <= 1'b0;
									state_q    <= S_RM_RL;
								end
							end
							CMD_DEL_MAX: begin
								if (cnt_q == '0) status_q <= ST_EMPTY;
								else if (cnt_q == COUNT_W'(1)) cnt_q <= '0;
								else begin
									want_max_q <= 1'b1;
									i_q        <= adr_t'(1);
									if (cnt_q > COUNT_W'(2)) state_q <= S_DX_R1;
									else begin
										cnt_q   <= cnt_q - 1'b1;
										state_q <= S_RM_RL;
									end
								end
							end
							default: ;
						endcase
					end
				end
				// ---- insert: parent check, then grandparent climb ----
				S_INS_W: begin
					if (i_q == '0) state_q <= S_OUT_R0;
					else begin
						j_q     <= par(i_q);
						state_q <= S_UP_RP;
					end
				end
				S_UP_RP: state_q <= S_UP_WP;
				S_UP_WP: begin
					if (on_min_level(i_q) ? cmp_gt : cmp_lt) begin
						vj_q       <= ram_rdata;
						want_max_q <= on_min_level(i_q);
						state_q    <= S_UP_SW1;
					end else begin
						want_max_q <= ~on_min_level(i_q);
						state_q    <= S_CL_START;
					end
				end
				S_UP_SW1: state_q <= S_UP_SW2;
				S_UP_SW2: begin
					i_q     <= j_q;
					state_q <= S_CL_START;
				end
				S_CL_START: begin
					if (i_q < adr_t'(3)) state_q <= S_OUT_R0;
					else begin
						j_q     <= par(par(i_q));
						state_q <= S_CL_RG;
					end
				end
				S_CL_RG: state_q <= S_CL_WG;
				S_CL_WG: begin
					if (better_dn) begin
						vj_q    <= ram_rdata;
						state_q <= S_CL_SW1;
					end else state_q <= S_OUT_R0;
				end
				S_CL_SW1: state_q <= S_CL_SW2;
				S_CL_SW2: begin
					i_q     <= j_q;
					state_q <= S_CL_START;
				end
				// ---- delete max: pick the larger level-1 slot, tie keeps slot 1 ----
				S_DX_R1: state_q <= S_DX_R2;
				S_DX_R2: begin vj_q <= ram_rdata; state_q <= S_DX_CMP; end
				S_DX_CMP: begin
					if (cmp_gt) i_q <= adr_t'(2);
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_RM_RL;
				end
				// ---- remove: move last entry into the target slot ----
				S_RM_RL: begin
					if (COUNT_W'(i_q) < cnt_q) state_q <= S_RM_WL;
					else state_q <= S_OUT_R0;
				end
				S_RM_WL: begin
					vi_q    <= ram_rdata;
					state_q <= S_RM_WR;
				end
				S_RM_WR: begin
					step_q  <= '0;
					m_q     <= i_q;
					state_q <= S_DN_RD;
				end
				// ---- sift down: scan up to 6 descendants, m_q == i_q means none yet ----
				S_DN_RD: begin
					if (step_q == 3'd6 || cand >= CAND_W'(cnt_q))
						state_q <= (m_q == i_q) ? S_OUT_R0 : S_DN_CMP;
					else state_q <= S_DN_WD;
				end
				S_DN_WD: begin
					if (m_q == i_q || better_dn) begin
						m_q  <= cand[ADDR_W-1:0];
						vm_q <= ram_rdata;
					end
					step_q  <= step_q + 3'd1;
					state_q <= S_DN_RD;
				end
				S_DN_CMP: state_q <= better_dn ? S_DN_SWI : S_OUT_R0;
				S_DN_SWI: state_q <= S_DN_SWM;
				S_DN_SWM: begin
					// a child ends the walk, a grandchild needs the parent check
					if (CAND_W'(m_q) < CAND_W'({i_q, 2'b11})) state_q <= S_OUT_R0;
					else state_q <= S_DN_RP;
				end
				S_DN_RP: state_q <= S_DN_WP;
				S_DN_WP: begin
					if (better_dn) begin
						vj_q    <= ram_rdata;
						state_q <= S_DN_PSW;
					end else begin
						i_q     <= m_q;
						step_q  <= '0;
						state_q <= S_DN_RD;
					end
				end
				S_DN_PSW: state_q <= S_DN_PSW2;
				S_DN_PSW2: begin
					vi_q    <= vj_q;
					i_q     <= m_q;
					step_q  <= '0;
					state_q <= S_DN_RD;
				end
				// ---- readout of min and max ----
				S_OUT_R0: state_q <= (cnt_q == '0) ? S_OUT : S_OUT_R1;
				S_OUT_R1: begin
					mn_q    <= ram_rdata;
					mx_q    <= ram_rdata;
					state_q <= (cnt_q >= COUNT_W'(2)) ? S_OUT_R2 : S_OUT;
				end
				S_OUT_R2: begin
					mx_q    <= ram_rdata;
					state_q <= (cnt_q > COUNT_W'(2)) ? S_OUT_R3 : S_OUT;
				end
				S_OUT_R3: begin
					if (cmp_gt) mx_q <= ram_rdata;
					state_q <= S_OUT;
				end
				S_OUT: begin
					done    <= 1'b1;
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.status      = status_q;
		rsp.entry_count = cnt_q;
		if (cnt_q == '0) begin
			rsp.min_value = '0;
			rsp.max_value = '0;
		end else begin
			rsp.min_value = {~mn_q[VALUE_WIDTH-1], mn_q[VALUE_WIDTH-2:0]};
			rsp.max_value = {~mx_q[VALUE_WIDTH-1], mx_q[VALUE_WIDTH-2:0]};
		end
	end
endmodule

[tb/sv/tb_min_max_heap_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_max_heap_engine: self-checking bench for the min-max heap engine
// Drives random and directed insert/delete items through several idle
// phases. A behavioral heap model predicts status, min, max and count per
// item, and a scoreboard compares each done strobe against it.
// ----------------------------------------------------------------------------
module tb_min_max_heap_engine;
	import mmh_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 1400;

	class heap_scoreboard;
		rsp_t pending[$];
		int   errors;
		int   checked;

		function void note_item(rsp_t exp_rsp);
			pending.insert(pending.size(), exp_rsp);
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp_rsp;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result status=%0d", got.status);
				errors++;
				return;
			end
			exp_rsp = pending.pop_front();
			if (got.status !== exp_rsp.status) begin
				$error("status exp %0d got %0d", exp_rsp.status, got.status);
				errors++;
			end
			if (got.min_value !== exp_rsp.min_value) begin
				$error("min_value exp %0d got %0d", exp_rsp.min_value, got.min_value);
				errors++;
			end
			if (got.max_value !== exp_rsp.max_value) begin
				$error("max_value exp %0d got %0d", exp_rsp.max_value, got.max_value);
				errors++;
			end
			if (got.entry_count !== exp_rsp.entry_count) begin
				$error("entry_count exp %0d got %0d", exp_rsp.entry_count,
					got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	req_t  req;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	heap_scoreboard sb;
	int    cycles;
	int    send_idle_pct;
	int    n_sent;
	int    n_ins, n_dmin, n_dmax, n_full, n_empty;

	// heap model state; values stored as signed
	logic signed [VALUE_WIDTH-1:0] heap[CAPACITY];
	int                            heap_cnt;

	min_max_heap_engine i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic bit is_min_level(int i);
		int v;
		int lvl;
		v = i + 1;
		lvl = 0;
		while (v > 1) begin
			v = v >> 1;
			lvl++;
		end
		return (lvl % 2) == 0;
	endfunction

	function automatic bit beats(logic signed [VALUE_WIDTH-1:0] a,
			logic signed [VALUE_WIDTH-1:0] b, bit want_max);
		return want_max ? (a > b) : (a < b);
	endfunction

	function automatic void swap_nodes(int i, int j);
		logic signed [VALUE_WIDTH-1:0] t;
		t = heap[i];
		heap[i] = heap[j];
		heap[j] = t;
	endfunction

	function automatic void climb_levels(int i, bit want_max);
		int g;
		while (i >= 3) begin
			g = (((i - 1) / 2) - 1) / 2;
			if (!beats(heap[i], heap[g], want_max)) break;
			swap_nodes(i, g);
			i = g;
		end
	endfunction

	function automatic void bubble_up(int i);
		int p;
		if (i == 0) return;
		p = (i - 1) / 2;
		if (is_min_level(i)) begin
			if (heap[i] > heap[p]) begin
				swap_nodes(i, p);
				climb_levels(p, 1'b1);
			end else begin
				climb_levels(i, 1'b0);
			end
		end else begin
			if (heap[i] < heap[p]) begin
				swap_nodes(i, p);
				climb_levels(p, 1'b0);
			end else begin
				climb_levels(i, 1'b1);
			end
		end
	endfunction

	function automatic void trickle_down(int i, bit want_max);
		int c, g0, m, p;
		forever begin
			c = 2 * i + 1;
			g0 = 4 * i + 3;
			if (c >= heap_cnt) return;
			m = c;
			if (c + 1 < heap_cnt && beats(heap[c + 1], heap[m], want_max)) m = c + 1;
			for (int k = g0; k < g0 + 4 && k < heap_cnt; k++)
				if (beats(heap[k], heap[m], want_max)) m = k;
			if (!beats(heap[m], heap[i], want_max)) return;
			swap_nodes(m, i);
			if (m < g0) return;
			p = (m - 1) / 2;
			if (beats(heap[p], heap[m], want_max)) swap_nodes(m, p);
			i = m;
		end
	endfunction

	function automatic void remove_node(int pos, bit want_max);
		heap_cnt--;
		if (pos < heap_cnt) begin
			heap[pos] = heap[heap_cnt];
			trickle_down(pos, want_max);
		end
	endfunction

	// applies one item to the model and returns the expected result
	function automatic rsp_t heap_apply(req_t r);
		rsp_t o;
		logic signed [VALUE_WIDTH-1:0] hi;
		o = '0;
		o.status = ST_OK;
		case (r.cmd)
			CMD_INSERT: begin
				if (heap_cnt >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					heap[heap_cnt] = r.key_value;
					heap_cnt++;
					bubble_up(heap_cnt - 1);
				end
			end
			CMD_DEL_MIN: begin
				if (heap_cnt == 0) o.status = ST_EMPTY;
				else remove_node(0, 1'b0);
			end
			CMD_DEL_MAX: begin
				if (heap_cnt == 0) o.status = ST_EMPTY;
				else if (heap_cnt == 1) heap_cnt = 0;
				else if (heap_cnt > 2 && heap[2] > heap[1]) remove_node(2, 1'b1);
				else remove_node(1, 1'b1);
			end
			default: ;
		endcase
		if (heap_cnt > 0) begin
			hi = heap[0];
			if (heap_cnt == 2) hi = heap[1];
			else if (heap_cnt > 2) hi = (heap[1] >= heap[2]) ? heap[1] : heap[2];
			o.min_value = heap[0];
			o.max_value = hi;
		end
		o.entry_count = heap_cnt[COUNT_W-1:0];
		return o;
	endfunction

	// start stays high after acceptance until the next idle cycle or new item
	task automatic send_item(logic [1:0] c, logic signed [VALUE_WIDTH-1:0] v);
		req_t r;
		r.cmd = c;
		r.key_value = v;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		// accepted at this edge
		sb.note_item(heap_apply(r));
		n_sent++;
		case (c)
			CMD_INSERT:  n_ins++;
			CMD_DEL_MIN: n_dmin++;
			CMD_DEL_MAX: n_dmax++;
			default: ;
		endcase
		if (sb.pending[$].status == ST_FULL) n_full++;
		if (sb.pending[$].status == ST_EMPTY) n_empty++;
	endtask

	function automatic logic signed [VALUE_WIDTH-1:0] rand_key();
		case ($urandom_range(5))
			0: return $signed($urandom_range(7)) - 4;
			1: return 32'sh7fffffff - $urandom_range(3);
			2: return 32'sh80000000 + $urandom_range(3);
			3: return $signed($urandom_range(40)) - 20;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic random_phase(int n, int idle_pct);
		int bias;
		logic [1:0] c;
		send_idle_pct = idle_pct;
		// drift between filling and draining so full and empty are both reached
		bias = 70;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0) bias = ($urandom_range(1)) ? 75 : 25;
			if ($urandom_range(99) < bias) c = CMD_INSERT;
			else if ($urandom_range(199) == 0) c = CMD_NONE;
			else c = $urandom_range(1) ? CMD_DEL_MIN : CMD_DEL_MAX;
			send_item(c, rand_key());
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(rsp);
	end

	initial begin
		sb = new();
		cycles = 0;
		n_sent = 0;
		n_ins = 0; n_dmin = 0; n_dmax = 0; n_full = 0; n_empty = 0;
		heap_cnt = 0;
		send_idle_pct = 0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty deletes, extremes, zero, ties, single-entry deletes
		send_item(CMD_DEL_MIN, 0);
		send_item(CMD_DEL_MAX, 0);
		send_item(CMD_INSERT, 0);
		send_item(CMD_DEL_MAX, 0);
		send_item(CMD_INSERT, 32'sh7fffffff);
		send_item(CMD_DEL_MIN, 0);
		send_item(CMD_INSERT, 32'sh80000000);
		send_item(CMD_INSERT, 32'sh7fffffff);
		send_item(CMD_INSERT, 5);
		send_item(CMD_INSERT, 5);
		send_item(CMD_INSERT, -1);
		send_item(CMD_NONE, 32'sh12345678);
		send_item(CMD_DEL_MAX, 0);
		send_item(CMD_DEL_MAX, 0);
		send_item(CMD_DEL_MIN, 0);
		send_item(CMD_DEL_MIN, 0);
		send_item(CMD_DEL_MIN, 0);
		send_item(CMD_DEL_MIN, 0);
		// fill to capacity and overflow, then drain past empty
		for (int i = 0; i < CAPACITY + 2; i++) send_item(CMD_INSERT, rand_key());
		for (int i = 0; i < CAPACITY + 2; i++)
			send_item(i % 2 ? CMD_DEL_MAX : CMD_DEL_MIN, 0);

		random_phase(N_RANDOM / 4, 0);
		random_phase(N_RANDOM / 4, 82);
		random_phase(N_RANDOM / 4, 10);
		random_phase(N_RANDOM / 4, 0);
		start <= 1'b0;

		while (sb.pending.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Ran %0d items: %0d inserts, %0d delete-min, %0d delete-max.",
			n_sent, n_ins, n_dmin, n_dmax);
		$display("Full rejections %0d, empty rejections %0d, results checked %0d.",
			n_full, n_empty, sb.checked);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
